// ===== hdl/bbc_pkg.sv =====
package bbc_pkg;

  localparam int NumEntriesDefault = 32;

  typedef enum logic [1:0] {
    REQ_GET     = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_PIN     = 2'd2,
    REQ_UNPIN   = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOBUF = 2'd1,
    ST_UNDER = 2'd2
  } status_code_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  device_id;
    logic [31:0] block_number;
    logic [4:0]  entry_index;
    logic [31:0] current_time;
  } req_t;

  typedef struct packed {
    logic [4:0] result_index;
    logic       was_hit;
    logic       needs_fill;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    logic valid;
    req_t data;
  } queue_out_t;

endpackage

// ===== hdl/bbc_front.sv =====
module bbc_front (
  input  logic              clk,
  input  logic              rst,
  input  bbc_pkg::req_t     req,
  input  logic              req_valid,
  output logic              req_stall,
  output bbc_pkg::queue_out_t q_out,
  input  logic              q_pop
);
  import bbc_pkg::*;

  req_t       slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign req_stall  = (fill == 2'd2);
  assign push       = req_valid && !req_stall;
  assign pop        = q_pop && (fill != 2'd0);
  assign q_out.valid = (fill != 2'd0);
  assign q_out.data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
    if (push) begin
      slot[wr_ptr] <= req;
    end
  end

endmodule

// ===== hdl/bbc_back.sv =====
module bbc_back #(
  parameter int NUM_ENTRIES = bbc_pkg::NumEntriesDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  bbc_pkg::queue_out_t q_in,
  output logic                q_pop,
  output bbc_pkg::rsp_t       rsp,
  output logic                rsp_valid,
  input  logic                rsp_stall
);
  import bbc_pkg::*;

  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  state_t       state;
  req_t         cur;
  logic [IW-1:0] cnt;
  logic [IW-1:0] sel;
  logic [IW-1:0] victim;
  logic         found;
  logic         have_free;

  logic [7:0]  tag_device     [NUM_ENTRIES];
  logic [31:0] tag_block      [NUM_ENTRIES];
  logic [7:0]  ref_count      [NUM_ENTRIES];
  logic [31:0] last_use_stamp [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] data_valid;

  logic [IW-1:0] idx;
  logic          idx_ok;
  logic          out_free;

  assign q_pop    = (state == S_IDLE) && q_in.valid;
  assign idx      = IW'(cur.entry_index);
  assign idx_ok   = {4'd0, cur.entry_index} < 9'(NUM_ENTRIES);
  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      data_valid <= '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        tag_device[i]     <= 8'd0;
        tag_block[i]      <= 32'd0;
        ref_count[i]      <= 8'd0;
        last_use_stamp[i] <= 32'd0;
      end
    end else begin
      if (rsp_valid && !rsp_stall && state != S_APPLY) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_in.valid) begin
            cur       <= q_in.data;
            cnt       <= '0;
            found     <= 1'b0;
            have_free <= 1'b0;
            state     <= (q_in.data.req_type == REQ_GET) ? S_SCAN : S_APPLY;
          end
        end
        S_SCAN: begin
          if (!found && tag_device[cnt] == cur.device_id &&
              tag_block[cnt] == cur.block_number) begin
            found <= 1'b1;
            sel   <= cnt;
          end
          if (ref_count[cnt] == 8'd0 &&
              (!have_free || last_use_stamp[cnt] < last_use_stamp[victim])) begin
            have_free <= 1'b1;
            victim    <= cnt;
          end
          if (cnt == IW'(NUM_ENTRIES - 1)) begin
            state <= S_APPLY;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_APPLY: begin
          if (out_free) begin
            rsp_valid        <= 1'b1;
            rsp.result_index <= cur.entry_index;
            rsp.was_hit      <= 1'b0;
            rsp.needs_fill   <= 1'b0;
            rsp.status       <= ST_OK;
            state            <= S_IDLE;
            if (cur.req_type == REQ_GET) begin
              if (found) begin
                if (ref_count[sel] != 8'hff) begin
                  ref_count[sel] <= ref_count[sel] + 8'd1;
                end
                rsp.was_hit      <= 1'b1;
                rsp.needs_fill   <= !data_valid[sel];
                data_valid[sel]  <= 1'b1;
                rsp.result_index <= 5'(sel);
              end else if (have_free) begin
                tag_device[victim] <= cur.device_id;
                tag_block[victim]  <= cur.block_number;
                ref_count[victim]  <= 8'd1;
                data_valid[victim] <= 1'b1;
                rsp.needs_fill     <= 1'b1;
                rsp.result_index   <= 5'(victim);
              end else begin
                rsp.status       <= ST_NOBUF;
                rsp.result_index <= 5'd0;
              end
            end else if (idx_ok) begin
              if (cur.req_type == REQ_PIN) begin
                if (ref_count[idx] != 8'hff) begin
                  ref_count[idx] <= ref_count[idx] + 8'd1;
                end
              end else if (ref_count[idx] == 8'd0) begin
                rsp.status <= ST_UNDER;
              end else begin
                ref_count[idx] <= ref_count[idx] - 8'd1;
                if (cur.req_type == REQ_RELEASE && ref_count[idx] == 8'd1) begin
                  last_use_stamp[idx] <= cur.current_time;
                end
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/block_buffer_cache_lru_core.sv =====
// buffer cache tag and replacement controller
// req channel: req (req_t), req_valid, req_stall; a transaction is taken
//   when req_valid is high and req_stall is low
// rsp channel: rsp (rsp_t), rsp_valid, rsp_stall; one response per request,
//   in request order
// a two-entry input queue accepts requests while the back end works
// get: the back end walks the entries one per cycle, then updates the
//   chosen entry and issues the response
// release, pin, unpin: no walk; the back end goes straight to the update
// the back end takes one request at a time and pops the next from the
//   queue only once it has issued the current response
// reset: all tags read (0, 0), counts and stamps zero, data invalid,
//   queue empty, no response pending
// when rsp_stall is high the response holds; the back end waits and the
//   queue fills, then req_stall rises
module block_buffer_cache_lru_core #(
  parameter int NUM_ENTRIES = bbc_pkg::NumEntriesDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  bbc_pkg::req_t req,
  input  logic          req_valid,
  output logic          req_stall,
  output bbc_pkg::rsp_t rsp,
  output logic          rsp_valid,
  input  logic          rsp_stall
);
  import bbc_pkg::*;

  queue_out_t q_out;
  logic       q_pop;

  bbc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .q_out     (q_out),
    .q_pop     (q_pop)
  );

  bbc_back #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_in      (q_out),
    .q_pop     (q_pop),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

endmodule

// ===== hdl/bbc_checker.sv =====
module bbc_checker (
  input logic          clk,
  input logic          rst,
  input bbc_pkg::req_t req,
  input logic          req_valid,
  input logic          req_stall,
  input bbc_pkg::rsp_t rsp,
  input logic          rsp_valid,
  input logic          rsp_stall
);
  import bbc_pkg::*;

  a_rst_clear: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("stalled request changed");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_nobuf: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_NOBUF |->
      rsp.result_index == 5'd0 && !rsp.was_hit && !rsp.needs_fill)
    else $error("no-buffer response carries data");

  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.was_hit |-> rsp.status == ST_OK)
    else $error("hit with error status");

endmodule

bind block_buffer_cache_lru_core bbc_checker u_bbc_checker (
  .clk       (clk),
  .rst       (rst),
  .req       (req),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp       (rsp),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall)
);

// ===== verif/block_buffer_cache_lru_core_tb.sv =====
module block_buffer_cache_lru_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bbc_pkg::*;

  localparam int NENT = 32;

  class cache_scoreboard;
    logic [7:0]  tag_dev [NENT];
    logic [31:0] tag_blk [NENT];
    logic [7:0]  refs [NENT];
    logic [31:0] stamp [NENT];
    logic        dvalid [NENT];
    rsp_t        pending_rsp [$];
    int          mismatches;
    int          checked;
    int          hits;
    int          misses;
    int          nobufs;
    int          unders;

    function void clear();
      for (int i = 0; i < NENT; i++) begin
        tag_dev[i] = '0;
        tag_blk[i] = '0;
        refs[i] = '0;
        stamp[i] = '0;
        dvalid[i] = 1'b0;
      end
      pending_rsp.delete();
      mismatches = 0;
      checked = 0;
      hits = 0;
      misses = 0;
      nobufs = 0;
      unders = 0;
    endfunction

    function void note_request(req_t r);
      rsp_t o;
      bit found;
      bit have_free;
      int sel;
      int victim;
      found = 0;
      have_free = 0;
      sel = 0;
      victim = 0;
      o.result_index = r.entry_index;
      o.was_hit = 1'b0;
      o.needs_fill = 1'b0;
      o.status = ST_OK;
      if (r.req_type == REQ_GET) begin
        for (int e = 0; e < NENT; e++) begin
          if (!found && tag_dev[e] == r.device_id && tag_blk[e] == r.block_number) begin
            found = 1;
            sel = e;
          end
          if (refs[e] == 0 && (!have_free || stamp[e] < stamp[victim])) begin
            have_free = 1;
            victim = e;
          end
        end
        if (found) begin
          if (refs[sel] != 8'hff) refs[sel]++;
          o.was_hit = 1'b1;
          o.needs_fill = !dvalid[sel];
          dvalid[sel] = 1'b1;
          o.result_index = sel[4:0];
          hits++;
        end else if (have_free) begin
          tag_dev[victim] = r.device_id;
          tag_blk[victim] = r.block_number;
          refs[victim] = 8'd1;
          o.needs_fill = 1'b1;
          dvalid[victim] = 1'b1;
          o.result_index = victim[4:0];
          misses++;
        end else begin
          o.status = ST_NOBUF;
          o.result_index = '0;
          nobufs++;
        end
      end else if (r.entry_index < NENT) begin
        if (r.req_type == REQ_PIN) begin
          if (refs[r.entry_index] != 8'hff) refs[r.entry_index]++;
        end else if (refs[r.entry_index] == 0) begin
          o.status = ST_UNDER;
          unders++;
        end else begin
          refs[r.entry_index]--;
          if (r.req_type == REQ_RELEASE && refs[r.entry_index] == 0)
            stamp[r.entry_index] = r.current_time;
        end
      end
      pending_rsp.push_back(o);
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      checked++;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
        return;
      end
      exp = pending_rsp.pop_front();
      if (got.result_index !== exp.result_index || got.was_hit !== exp.was_hit ||
          got.needs_fill !== exp.needs_fill || got.status !== exp.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"response %0d: expected idx %0d hit %0b fill %0b st %0d,",
                    " got idx %0d hit %0b fill %0b st %0d"},
                   checked, exp.result_index, exp.was_hit, exp.needs_fill, exp.status,
                   got.result_index, got.was_hit, got.needs_fill, got.status);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  req_t req;
  logic req_valid;
  logic req_stall;
  rsp_t rsp;
  logic rsp_valid;
  logic rsp_stall;

  cache_scoreboard sb;
  int hold_cycles;
  bit long_done;

  block_buffer_cache_lru_core #(.NUM_ENTRIES(NENT)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_request(req_t r, bit allow_gap);
    int gap;
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
  endtask

  function automatic req_t make_req(req_code_t t, logic [7:0] dev, logic [31:0] blk,
                                    logic [4:0] idx, logic [31:0] now);
    req_t r;
    r.req_type = t;
    r.device_id = dev;
    r.block_number = blk;
    r.entry_index = idx;
    r.current_time = now;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int k;
    r.device_id = 8'($urandom_range(0, 3));
    r.block_number = 32'($urandom_range(0, 47));
    if ($urandom_range(0, 9) == 0) begin
      r.device_id = 8'($urandom);
      r.block_number = $urandom;
    end
    r.entry_index = 5'($urandom);
    r.current_time = $urandom;
    k = $urandom_range(0, 99);
    if (k < 40) r.req_type = REQ_GET;
    else if (k < 80) r.req_type = REQ_RELEASE;
    else if (k < 90) r.req_type = REQ_PIN;
    else r.req_type = REQ_UNPIN;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  initial begin
    rsp_stall = 1'b0;
    hold_cycles = 0;
    long_done = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp_stall <= 1'b1;
      end else if (!long_done && sb.checked >= 300) begin
        long_done = 1;
        rsp_stall <= 1'b1;
        hold_cycles = 300;
      end else if ($urandom_range(0, 3) == 0) begin
        rsp_stall <= 1'b1;
        hold_cycles = pick_gap();
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int n;
    sb = new();
    sb.clear();
    rst = 1'b1;
    req = '0;
    req_valid = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset tags and lowest-index hit
    send_request(make_req(REQ_GET, 8'd0, 32'd0, 5'd0, 32'd0), 0);
    send_request(make_req(REQ_GET, 8'd0, 32'd0, 5'd31, 32'hffff_ffff), 0);
    send_request(make_req(REQ_GET, 8'hff, 32'hffff_ffff, 5'd0, 32'd0), 0);
    send_request(make_req(REQ_RELEASE, 8'd0, 32'd0, 5'd0, 32'hffff_ffff), 0);
    send_request(make_req(REQ_RELEASE, 8'd0, 32'd0, 5'd0, 32'd5), 0);
    send_request(make_req(REQ_UNPIN, 8'd0, 32'd0, 5'd0, 32'd0), 0);
    send_request(make_req(REQ_UNPIN, 8'd0, 32'd0, 5'd31, 32'd0), 0);
    send_request(make_req(REQ_PIN, 8'd0, 32'd0, 5'd31, 32'd0), 0);
    send_request(make_req(REQ_RELEASE, 8'd0, 32'd0, 5'd31, 32'hffff_ffff), 0);
    send_request(make_req(REQ_GET, 8'd0, 32'd0, 5'd0, 32'd0), 0);
    send_request(make_req(REQ_GET, 8'h80, 32'h8000_0000, 5'd0, 32'd0), 0);
    // repeated pins on one entry
    for (int i = 0; i < 8; i++)
      send_request(make_req(REQ_PIN, 8'd0, 32'd0, 5'd2, 32'd0), 0);
    // exhaust free entries, then no free buffer, then saturation of the count on one entry
    for (int i = 0; i < NENT + 2; i++)
      send_request(make_req(REQ_GET, 8'd9, i, 5'd0, 32'd0), 0);
    for (int i = 0; i < 260; i++)
      send_request(make_req(REQ_PIN, 8'd0, 32'd0, 5'd3, 32'd0), 0);
    // back pressure while requests keep coming
    for (int i = 0; i < 10; i++)
      send_request(make_req(REQ_RELEASE, 8'd0, 32'd0, i[4:0], $urandom), 0);

    n = 0;
    while (n < 480) begin
      send_request(random_req(), 1);
      n++;
    end
    req_valid <= 1'b0;

    n = 0;
    while (sb.pending_rsp.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (100) @(posedge clk);
    $display("covered %0d responses: %0d hits, %0d misses, %0d no-buffer, %0d underflows",
             sb.checked, sb.hits, sb.misses, sb.nobufs, sb.unders);
    if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d responses missing", sb.mismatches, sb.pending_rsp.size());
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/bbc_pkg.sv
hdl/bbc_front.sv
hdl/bbc_back.sv
hdl/block_buffer_cache_lru_core.sv
hdl/bbc_checker.sv
verif/block_buffer_cache_lru_core_tb.sv
